// ----- sv/pafit_pkg.sv -----
`default_nettype none

package pafit_pkg;

    // Window and iteration limits
    localparam int MAX_BINS  = 256;
    localparam int MAX_STEPS = 40;

    // Field widths
    localparam int CNT_W   = 16;
    localparam int BASE_W  = 32;
    localparam int FIX_W   = 32;
    localparam int TPL_W   = 16;
    localparam int BIN_W   = CNT_W + BASE_W + FIX_W + TPL_W;
    localparam int AMPC_W  = 32;
    localparam int MASS_W  = 24;
    localparam int BG_W    = 32;
    localparam int STEP_W  = 6;
    localparam int OUT_W   = 64;

    // Internal widths
    localparam int IDX_W   = $clog2(MAX_BINS);
    localparam int NB_W    = $clog2(MAX_BINS + 1);
    localparam int S_W     = 17;
    localparam int AMP_W   = 40;
    localparam int MU_W    = 44;
    localparam int R_W     = 48;
    localparam int Q_W     = 48;
    localparam int G_W     = 48;
    localparam int H_W     = 64;
    localparam int SEED_W  = 48;
    localparam int RES_W   = 36;
    localparam int DIV_W   = 64;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_AMP    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MASS_FLOOR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND = 2'd2;

    localparam logic [AMPC_W-1:0] MAX_AMP_RESET = 32'd65536000;

    // Divider operand selection
    localparam logic [2:0] DIV_S  = 3'd0;   // template / mass
    localparam logic [2:0] DIV_R  = 3'd1;   // count / mu
    localparam logic [2:0] DIV_HT = 3'd2;   // q*s / mu
    localparam logic [2:0] DIV_D  = 3'd3;   // |grad| / curvature
    localparam logic [2:0] DIV_F  = 3'd4;   // amplitude / mass

    typedef struct packed {
        logic       load;
        logic       calc_upper;
        logic       seed_amp;
        logic       pass_init;
        logic       rd_bin;
        logic       div_start;
        logic [2:0] div_sel;
        logic       mul_as;
        logic       calc_mu;
        logic       mul_sr;
        logic       mul_qs;
        logic       acc_bin;
        logic       apply_step;
        logic       out_load;
    } pafit_cmd_t;

    typedef struct packed {
        logic mass_ok;
        logic last_idx;
        logic pass_stop;
        logic step_stop;
        logic div_busy;
        logic out_free;
    } pafit_sts_t;

endpackage

`default_nettype wire

// ----- sv/pafit_ram.sv -----
`default_nettype none

module pafit_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Single write port, registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- sv/pafit_div.sv -----
`default_nettype none

module pafit_div
    import pafit_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [DIV_W-1:0] dividend,
    input  wire logic [DIV_W-1:0] divisor,
    output      logic             busy,
    output      logic [DIV_W-1:0] quotient
);

    localparam int CW = $clog2(DIV_W);

    logic [DIV_W-1:0] rem_reg;
    logic [DIV_W-1:0] quo_reg;
    logic [DIV_W-1:0] dvs_reg;
    logic [CW-1:0]    cnt_reg;
    logic             busy_reg;
    logic [DIV_W:0]   shifted;
    logic             fits;

    // One quotient bit per cycle, restoring
    assign shifted = {rem_reg, quo_reg[DIV_W-1]};
    assign fits    = shifted >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CW'(DIV_W - 1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? DIV_W'(shifted - {1'b0, dvs_reg}) : shifted[DIV_W-1:0];
            quo_reg <= {quo_reg[DIV_W-2:0], fits};
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// ----- sv/pafit_datapath.sv -----
`default_nettype none

module pafit_datapath
    import pafit_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire pafit_cmd_t           cmd,
    output      pafit_sts_t           sts,
    input  wire logic [BIN_W-1:0]     bin_word,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [AMPC_W-1:0]    cfg_wdata,
    output      logic                 out_valid,
    output      logic                 out_fit_ok,
    output      logic [OUT_W-1:0]     out_data,
    input  wire logic                 out_ready
);

    // Configuration
    logic [AMPC_W-1:0] max_amp_reg;
    logic [MASS_W-1:0] mass_floor_reg;
    logic [BG_W-1:0]   bg_reg;

    // Window accumulation
    logic [NB_W-1:0]   bins_reg;
    logic [MASS_W-1:0] mass_reg;
    logic [SEED_W-1:0] seed_reg;

    // Fit state
    logic              fit_ok_reg;
    logic [AMP_W-1:0]  upper_reg;
    logic [AMP_W-1:0]  amp_reg;
    logic [STEP_W-1:0] steps_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [G_W-1:0]    g_reg;
    logic [H_W-1:0]    h_reg;
    logic [S_W-1:0]    s_reg;
    logic [AMP_W+S_W-1:0] prod_as_reg;
    logic [MU_W-1:0]   mu_reg;
    logic [Q_W-1:0]    q_reg;
    logic [DIV_W-1:0]  qs_reg;

    // Output register
    logic              ov_reg;
    logic              ook_reg;
    logic [OUT_W-1:0]  od_reg;

    logic [BIN_W-1:0]  rdata;
    logic [CNT_W-1:0]  in_cnt, rd_cnt;
    logic [BASE_W-1:0] in_base, rd_base;
    logic [FIX_W-1:0]  in_fix, rd_fix;
    logic [TPL_W-1:0]  in_tpl, rd_tpl;

    assign in_cnt  = bin_word[CNT_W-1:0];
    assign in_base = bin_word[CNT_W+BASE_W-1:CNT_W];
    assign in_fix  = bin_word[CNT_W+BASE_W+FIX_W-1:CNT_W+BASE_W];
    assign in_tpl  = bin_word[BIN_W-1:CNT_W+BASE_W+FIX_W];
    assign rd_cnt  = rdata[CNT_W-1:0];
    assign rd_base = rdata[CNT_W+BASE_W-1:CNT_W];
    assign rd_fix  = rdata[CNT_W+BASE_W+FIX_W-1:CNT_W+BASE_W];
    assign rd_tpl  = rdata[BIN_W-1:CNT_W+BASE_W+FIX_W];

    logic room;
    assign room = bins_reg < NB_W'(MAX_BINS);

    pafit_ram #(
        .WIDTH (BIN_W),
        .DEPTH (MAX_BINS)
    ) u_bins (
        .clk   (clk),
        .we    (cmd.load && room),
        .waddr (bins_reg[IDX_W-1:0]),
        .wdata (bin_word),
        .re    (cmd.rd_bin),
        .raddr (idx_reg),
        .rdata (rdata)
    );

    // Load-time sums: template mass and positive residual seed
    logic [MASS_W:0]  mass_sum;
    logic [RES_W-1:0] res;
    assign mass_sum = {1'b0, mass_reg} + (MASS_W+1)'(in_tpl);
    assign res = RES_W'({in_cnt, 16'b0}) - RES_W'(in_base)
               - RES_W'($signed(in_fix)) - RES_W'($signed(bg_reg));

    // Shared divider operands
    logic [DIV_W-1:0] div_a, div_b, div_q;
    logic [G_W-1:0]   g_mag;
    logic             div_busy;
    assign g_mag = g_reg[G_W-1] ? G_W'(-g_reg) : g_reg;

    always_comb
    begin
        case (cmd.div_sel)
            DIV_S:
            begin
                div_a = DIV_W'({rd_tpl, 16'b0});
                div_b = DIV_W'(mass_reg);
            end
            DIV_R:
            begin
                div_a = DIV_W'({rd_cnt, 32'b0});
                div_b = DIV_W'(mu_reg);
            end
            DIV_HT:
            begin
                div_a = qs_reg;
                div_b = DIV_W'(mu_reg);
            end
            DIV_D:
            begin
                div_a = DIV_W'({g_mag, 16'b0});
                div_b = h_reg;
            end
            default:
            begin
                div_a = DIV_W'({amp_reg, 16'b0});
                div_b = DIV_W'(mass_reg);
            end
        endcase
    end

    pafit_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .busy     (div_busy),
        .quotient (div_q)
    );

    // Expected count of the current bin
    logic [MU_W-1:0] mu_sum;
    assign mu_sum = MU_W'(rd_base) + MU_W'(prod_as_reg[AMP_W+S_W-1:16])
                  + (rd_fix[FIX_W-1] ? '0 : MU_W'(rd_fix[FIX_W-2:0]))
                  + (bg_reg[BG_W-1] ? '0 : MU_W'(bg_reg[BG_W-2:0]));

    // Gradient and curvature accumulation, saturating
    logic [S_W+R_W-1:0] sr_prod;
    logic [G_W+1:0]     g_sum;
    logic [H_W:0]       h_sum;
    logic [G_W-1:0]     g_sat;
    assign sr_prod = S_W'(s_reg) * R_W'(div_q);
    assign g_sum = (G_W+2)'($signed(g_reg)) + (G_W+2)'(s_reg) - (G_W+2)'(q_reg);
    assign h_sum = {1'b0, h_reg} + {1'b0, div_q};

    always_comb
    begin
        if (g_sum[G_W+1:G_W-1] == 3'b000 || g_sum[G_W+1:G_W-1] == 3'b111)
        begin
            g_sat = g_sum[G_W-1:0];
        end
        else if (g_sum[G_W+1])
        begin
            g_sat = {1'b1, {(G_W-1){1'b0}}};
        end
        else
        begin
            g_sat = {1'b0, {(G_W-1){1'b1}}};
        end
    end

    // Clamped Newton candidate
    logic [AMP_W-1:0] cand;
    logic [AMP_W-1:0] headroom;
    assign headroom = upper_reg - amp_reg;

    always_comb
    begin
        if (!g_reg[G_W-1])
        begin
            cand = (div_q >= DIV_W'(amp_reg)) ? '0 : AMP_W'(amp_reg - div_q[AMP_W-1:0]);
        end
        else
        begin
            cand = (div_q >= DIV_W'(headroom)) ? upper_reg
                                               : AMP_W'(amp_reg + div_q[AMP_W-1:0]);
        end
    end

    logic [MASS_W+AMPC_W-1:0] upper_prod;
    assign upper_prod = max_amp_reg * MASS_W'(mass_reg);

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_amp_reg    <= MAX_AMP_RESET;
            mass_floor_reg <= '0;
            bg_reg         <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MAX_AMP:    max_amp_reg    <= cfg_wdata;
                CFG_MASS_FLOOR: mass_floor_reg <= cfg_wdata[MASS_W-1:0];
                CFG_BACKGROUND: bg_reg         <= cfg_wdata;
                default:        ;
            endcase
        end
    end

    // Window and fit control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bins_reg   <= '0;
            mass_reg   <= '0;
            seed_reg   <= '0;
            fit_ok_reg <= 1'b0;
            steps_reg  <= '0;
            idx_reg    <= '0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            if (cmd.load && room)
            begin
                bins_reg <= bins_reg + 1'b1;
                mass_reg <= mass_sum[MASS_W] ? '1 : mass_sum[MASS_W-1:0];
                if (!res[RES_W-1] && res != '0)
                begin
                    seed_reg <= seed_reg + SEED_W'(res);
                end
            end
            if (cmd.calc_upper)
            begin
                fit_ok_reg <= mass_reg > mass_floor_reg;
            end
            if (cmd.seed_amp)
            begin
                steps_reg <= '0;
            end
            if (cmd.pass_init)
            begin
                idx_reg <= '0;
            end
            if (cmd.acc_bin)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (cmd.apply_step)
            begin
                steps_reg <= steps_reg + 1'b1;
            end
            // Result hand-off clears the valid flag; loading a result clears the window
            if (out_ready)
            begin
                ov_reg <= 1'b0;
            end
            if (cmd.out_load)
            begin
                ov_reg   <= 1'b1;
                bins_reg <= '0;
                mass_reg <= '0;
                seed_reg <= '0;
            end
        end
    end

    // Arithmetic registers
    always_ff @(posedge clk)
    begin
        if (cmd.calc_upper)
        begin
            upper_reg <= upper_prod[MASS_W+AMPC_W-1:16];
        end
        if (cmd.seed_amp)
        begin
            amp_reg <= (seed_reg > SEED_W'(upper_reg)) ? upper_reg : seed_reg[AMP_W-1:0];
        end
        if (cmd.pass_init)
        begin
            g_reg <= '0;
            h_reg <= '0;
        end
        if (cmd.mul_as)
        begin
            s_reg       <= div_q[S_W-1:0];
            prod_as_reg <= amp_reg * div_q[S_W-1:0];
        end
        if (cmd.calc_mu)
        begin
            mu_reg <= (mu_sum == '0) ? MU_W'(1) : mu_sum;
        end
        if (cmd.mul_sr)
        begin
            q_reg <= sr_prod[Q_W+15:16];
        end
        if (cmd.mul_qs)
        begin
            qs_reg <= DIV_W'(q_reg * s_reg);
        end
        if (cmd.acc_bin)
        begin
            g_reg <= g_sat;
            h_reg <= h_sum[H_W] ? '1 : h_sum[H_W-1:0];
        end
        if (cmd.apply_step)
        begin
            amp_reg <= cand;
        end
        if (cmd.out_load)
        begin
            ook_reg <= fit_ok_reg;
            if (fit_ok_reg)
            begin
                od_reg <= {2'b00, steps_reg, mass_reg,
                           (div_q[DIV_W-1:AMPC_W] != '0) ? {AMPC_W{1'b1}}
                                                         : div_q[AMPC_W-1:0]};
            end
            else
            begin
                od_reg <= {2'b00, STEP_W'(0), mass_reg, AMPC_W'(0)};
            end
        end
    end

    // Status back to the controller
    always_comb
    begin
        sts.mass_ok   = mass_reg > mass_floor_reg;
        sts.last_idx  = NB_W'(idx_reg) + 1'b1 == bins_reg;
        sts.pass_stop = g_reg == '0 || h_reg == '0;
        sts.step_stop = cand == amp_reg || steps_reg == STEP_W'(MAX_STEPS - 1);
        sts.div_busy  = div_busy;
        sts.out_free  = !ov_reg || out_ready;
    end

    assign out_valid  = ov_reg;
    assign out_fit_ok = ook_reg;
    assign out_data   = od_reg;

endmodule

`default_nettype wire

// ----- sv/pafit_ctrl.sv -----
`default_nettype none

module pafit_ctrl
    import pafit_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire logic       in_last,
    output      logic       in_ready,
    input  wire pafit_sts_t sts,
    output      pafit_cmd_t cmd
);

    localparam logic [4:0] ST_IDLE  = 5'd0;
    localparam logic [4:0] ST_CHECK = 5'd1;
    localparam logic [4:0] ST_SEED  = 5'd2;
    localparam logic [4:0] ST_PASS  = 5'd3;
    localparam logic [4:0] ST_RD    = 5'd4;
    localparam logic [4:0] ST_DS    = 5'd5;
    localparam logic [4:0] ST_WS    = 5'd6;
    localparam logic [4:0] ST_MUL1  = 5'd7;
    localparam logic [4:0] ST_MU    = 5'd8;
    localparam logic [4:0] ST_DR    = 5'd9;
    localparam logic [4:0] ST_WR    = 5'd10;
    localparam logic [4:0] ST_MUL2  = 5'd11;
    localparam logic [4:0] ST_MUL3  = 5'd12;
    localparam logic [4:0] ST_DH    = 5'd13;
    localparam logic [4:0] ST_WH    = 5'd14;
    localparam logic [4:0] ST_ACC   = 5'd15;
    localparam logic [4:0] ST_ENDP  = 5'd16;
    localparam logic [4:0] ST_WD    = 5'd17;
    localparam logic [4:0] ST_STEP  = 5'd18;
    localparam logic [4:0] ST_FIN   = 5'd19;
    localparam logic [4:0] ST_WF    = 5'd20;
    localparam logic [4:0] ST_RES   = 5'd21;

    logic [4:0] state_reg;
    logic [4:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Sequencing of load, Newton passes and result
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
                if (in_valid && in_last)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                cmd.calc_upper = 1'b1;
                state_next = sts.mass_ok ? ST_SEED : ST_RES;
            end
            ST_SEED:
            begin
                cmd.seed_amp = 1'b1;
                state_next = ST_PASS;
            end
            ST_PASS:
            begin
                cmd.pass_init = 1'b1;
                state_next = ST_RD;
            end
            ST_RD:
            begin
                cmd.rd_bin = 1'b1;
                state_next = ST_DS;
            end
            ST_DS:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_S;
                state_next = ST_WS;
            end
            ST_WS:
            begin
                if (!sts.div_busy)
                begin
                    state_next = ST_MUL1;
                end
            end
            ST_MUL1:
            begin
                cmd.mul_as = 1'b1;
                state_next = ST_MU;
            end
            ST_MU:
            begin
                cmd.calc_mu = 1'b1;
                state_next = ST_DR;
            end
            ST_DR:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_R;
                state_next = ST_WR;
            end
            ST_WR:
            begin
                if (!sts.div_busy)
                begin
                    state_next = ST_MUL2;
                end
            end
            ST_MUL2:
            begin
                cmd.mul_sr = 1'b1;
                state_next = ST_MUL3;
            end
            ST_MUL3:
            begin
                cmd.mul_qs = 1'b1;
                state_next = ST_DH;
            end
            ST_DH:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_HT;
                state_next = ST_WH;
            end
            ST_WH:
            begin
                if (!sts.div_busy)
                begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC:
            begin
                cmd.acc_bin = 1'b1;
                state_next = sts.last_idx ? ST_ENDP : ST_RD;
            end
            ST_ENDP:
            begin
                if (sts.pass_stop)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_D;
                    state_next = ST_WD;
                end
            end
            ST_WD:
            begin
                if (!sts.div_busy)
                begin
                    state_next = ST_STEP;
                end
            end
            ST_STEP:
            begin
                cmd.apply_step = 1'b1;
                state_next = sts.step_stop ? ST_FIN : ST_PASS;
            end
            ST_FIN:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_F;
                state_next = ST_WF;
            end
            ST_WF:
            begin
                if (!sts.div_busy)
                begin
                    state_next = ST_RES;
                end
            end
            ST_RES:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- sv/poisson_amplitude_newton_fit.sv -----
// Poisson amplitude fit of one pulse template over a histogram window.
// Slave stream: one bin word per beat, tlast on the final bin of the window.
// Bins are taken one per cycle; bins past MAX_BINS are dropped, and their
// tlast still ends the window. On the tlast beat the fit starts and
// s_tready stays low until its result is placed in the output register.
// Master stream: one result word per window, tuser = fit_valid.
// The fit runs P passes over the N stored bins and takes S Newton steps
// (P is S, or S + 1 when a pass ends on zero gradient or curvature); a
// window of low mass skips the passes. Each division runs on the one shared
// bit-serial divider, three of them per bin of a pass.
// The output register holds a result while m_tready is low; the next
// window loads meanwhile, and a finished fit waits for the register.
// Reset (rst_n low, asynchronous) empties the window, drops any pending
// result and restores the configuration reset values. The bin memory is
// not cleared; only bins of the current window are ever read.
// Configuration writes take effect at once and belong between windows.
`default_nettype none

module poisson_amplitude_newton_fit
    import pafit_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output      logic                 s_tready,
    // observed count, base expectation, fixed expectation, template value
    input  wire logic [BIN_W-1:0]     s_tdata,
    input  wire logic                 s_tlast,
    output      logic                 m_tvalid,
    input  wire logic                 m_tready,
    // fitted_amplitude, template_mass, steps_used, zero pad
    output      logic [OUT_W-1:0]     m_tdata,
    // fit_valid
    output      logic                 m_tuser,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [AMPC_W-1:0]    cfg_wdata
);

    pafit_cmd_t cmd;
    pafit_sts_t sts;

    pafit_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_last  (s_tlast),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    pafit_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .bin_word   (s_tdata),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .out_valid  (m_tvalid),
        .out_fit_ok (m_tuser),
        .out_data   (m_tdata),
        .out_ready  (m_tready)
    );

`ifndef NO_ASSERTIONS
    // The divider is only started when idle
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> !sts.div_busy)
        else $error("divider started while busy");

    // Invalid fits report zero amplitude and zero steps
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata[31:0] == '0 && m_tdata[61:56] == '0))
        else $error("invalid fit with nonzero amplitude or steps");

    // Step count never exceeds the limit
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[61:56] <= STEP_W'(MAX_STEPS))
        else $error("step count beyond limit");

    // No bin is taken while the fit is running
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.div_start || sts.div_busy) |-> !s_tready)
        else $error("input ready during fit");
`endif

endmodule

`default_nettype wire
